// ===== sv/smm_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted multiset package
// Shared sizes, codes and the per-beat command that drives the cell chain.
// ----------------------------------------------------------------------------
package smm_pkg;

  localparam int CAPACITY = 64;
  localparam int DATA_W   = 32;
  localparam int PROD_W   = 64;
  localparam int OCC_W    = 7;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    STAT_DONE   = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_ABSENT = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEL,
    ST_MUL
  } state_t;

  typedef struct packed {
    logic              push;
    logic              pop;
    logic [DATA_W-1:0] v;
  } smm_cmd_t;

endpackage

// ===== sv/sorted_multiset_min_max_product_unit.sv =====
// ----------------------------------------------------------------------------
// Sorted multiset min-max product unit
// After the accepting edge the unit steps through ST_SEL and ST_MUL, and the
// result and its strobe are registered as ST_MUL ends. No new beat is taken
// while busy: the cell chain updates at the accepting edge, then the extreme
// entries are selected and multiplied. Reset empties the set; an empty set
// gives a zero product. The receiver cannot stall: done is a one-cycle strobe.
// ----------------------------------------------------------------------------
module sorted_multiset_min_max_product_unit import smm_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic                     mode,
  input  logic signed [DATA_W-1:0] operand,
  output logic                     busy,
  output logic                     done,
  output logic signed [PROD_W-1:0] product,
  output logic [1:0]               status,
  output logic [OCC_W-1:0]         occupancy
);

  state_t                   state, state_next;
  smm_cmd_t                 cmd;
  logic                     accept;
  logic                     found;
  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         last;
  logic signed [DATA_W-1:0] entries [CAPACITY];
  logic signed [DATA_W-1:0] lo;
  logic signed [DATA_W-1:0] hi;
  logic signed [PROD_W-1:0] mul;
  status_t                  stat;
  logic                     full;

  assign accept   = start && !busy;
  assign full     = (count >= CNT_W'(CAPACITY));
  assign cmd.push = accept && !mode && !full;
  assign cmd.pop  = accept && mode && found;
  assign cmd.v    = operand;
  assign last     = count - CNT_W'(1);
  assign mul      = lo * hi;

  smm_chain u_chain (
    .clk     (clk),
    .cmd     (cmd),
    .count   (count),
    .entries (entries),
    .found   (found)
  );

  always_comb begin
    state_next = state;
    busy       = 1'b1;
    unique case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          state_next = ST_SEL;
        end
      end
      ST_SEL: begin
        state_next = ST_MUL;
      end
      ST_MUL: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == ST_MUL);
      if (cmd.push) begin
        count <= count + CNT_W'(1);
      end else if (cmd.pop) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (!mode) begin
        stat <= full ? STAT_FULL : STAT_DONE;
      end else begin
        stat <= found ? STAT_DONE : STAT_ABSENT;
      end
    end
    if (state == ST_SEL) begin
      lo <= entries[0];
      hi <= entries[last[IDX_W-1:0]];
    end
    if (state == ST_MUL) begin
      product   <= (count == '0) ? '0 : mul;
      status    <= stat;
      occupancy <= OCC_W'(count);
    end
  end

endmodule

// ===== sv/smm_cell.sv =====
// ----------------------------------------------------------------------------
// Sorted multiset cell
// Holds one entry; on a push it shifts right or takes the new value, on a
// pop it shifts left from its right neighbor.
// ----------------------------------------------------------------------------
module smm_cell import smm_pkg::*; (
  input  logic                     clk,
  input  smm_cmd_t                 cmd,
  input  logic                     held,
  input  logic signed [DATA_W-1:0] left_entry,
  input  logic                     left_ins,
  input  logic                     left_ge,
  input  logic signed [DATA_W-1:0] right_entry,
  output logic signed [DATA_W-1:0] entry,
  output logic                     ins,
  output logic                     ge,
  output logic                     hit
);

  logic signed [DATA_W-1:0] v;

  assign v   = $signed(cmd.v);
  assign ins = !held || (entry > v);
  assign ge  = held && (entry >= v);
  assign hit = ge && !left_ge && (entry == v);

  always_ff @(posedge clk) begin
    if (cmd.push && ins) begin
      entry <= left_ins ? left_entry : v;
    end else if (cmd.pop && ge) begin
      entry <= right_entry;
    end
  end

endmodule

// ===== sv/smm_chain.sv =====
// ----------------------------------------------------------------------------
// Sorted multiset cell chain
// A row of cells in ascending order, with the pop match reduced over the row.
// ----------------------------------------------------------------------------
module smm_chain import smm_pkg::*; (
  input  logic                     clk,
  input  smm_cmd_t                 cmd,
  input  logic [CNT_W-1:0]         count,
  output logic signed [DATA_W-1:0] entries [CAPACITY],
  output logic                     found
);

  logic [CAPACITY-1:0] held;
  logic [CAPACITY-1:0] ins;
  logic [CAPACITY-1:0] ge;
  logic [CAPACITY-1:0] hit;

  assign found = |hit;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_entry;
    logic signed [DATA_W-1:0] right_entry;
    logic                     left_ins;
    logic                     left_ge;

    assign held[i] = (CNT_W'(i) < count);

    if (i == 0) begin : g_first
      assign left_entry = entries[i];
      assign left_ins   = 1'b0;
      assign left_ge    = 1'b0;
    end else begin : g_mid
      assign left_entry = entries[i-1];
      assign left_ins   = ins[i-1];
      assign left_ge    = ge[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_entry = entries[i];
    end else begin : g_inner
      assign right_entry = entries[i+1];
    end

    smm_cell u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .held        (held[i]),
      .left_entry  (left_entry),
      .left_ins    (left_ins),
      .left_ge     (left_ge),
      .right_entry (right_entry),
      .entry       (entries[i]),
      .ins         (ins[i]),
      .ge          (ge[i]),
      .hit         (hit[i])
    );
  end

endmodule

// ===== test/smm_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted multiset testbench package
// Command codes shared by the stimulus generator and the result checker.
// ----------------------------------------------------------------------------
package smm_tb_pkg;

  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_POP  = 1'b1;

endpackage

// ===== test/smm_checker.sv =====
// ----------------------------------------------------------------------------
// Sorted multiset result checker
// Watches the command and result channels of the min-max product unit, keeps
// its own sorted copy of the set, and compares every result beat, field by
// field, with the oldest predicted beat.
// ----------------------------------------------------------------------------
module smm_checker import smm_pkg::*; import smm_tb_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic                     busy,
  input  logic                     mode,
  input  logic signed [DATA_W-1:0] operand,
  input  logic                     done,
  input  logic signed [PROD_W-1:0] product,
  input  logic [1:0]               status,
  input  logic [OCC_W-1:0]         occupancy,
  output int                       errors,
  output int                       outstanding,
  output int                       full_drops,
  output int                       missing_pops
);

  typedef struct {
    logic signed [PROD_W-1:0] product;
    status_t                  status;
    logic [OCC_W-1:0]         occupancy;
  } set_report_t;

  set_report_t              pending_reports[$];
  logic signed [DATA_W-1:0] held [CAPACITY];
  int                       held_count = 0;
  int                       err_cnt    = 0;
  int                       full_cnt   = 0;
  int                       absent_cnt = 0;

  function automatic set_report_t update_set(input logic m, input logic signed [DATA_W-1:0] v);
    set_report_t r;
    int          pos;
    int          k;
    r.status = STAT_DONE;
    if (m == MODE_PUSH) begin
      if (held_count >= CAPACITY) begin
        r.status = STAT_FULL;
      end else begin
        pos = held_count;
        while (pos > 0 && held[pos-1] > v) pos--;
        for (k = held_count; k > pos; k--) held[k] = held[k-1];
        held[pos] = v;
        held_count++;
      end
    end else begin
      pos = 0;
      while (pos < held_count && held[pos] != v) pos++;
      if (pos >= held_count) begin
        r.status = STAT_ABSENT;
      end else begin
        for (k = pos; k + 1 < held_count; k++) held[k] = held[k+1];
        held_count--;
      end
    end
    if (held_count > 0) r.product = longint'(held[0]) * longint'(held[held_count-1]);
    else r.product = '0;
    r.occupancy = OCC_W'(held_count);
    return r;
  endfunction

  always @(posedge clk) begin
    set_report_t want;
    if (rst) begin
      held_count = 0;
      pending_reports.delete();
    end else begin
      if (done) begin
        if (pending_reports.size() == 0) begin
          err_cnt++;
          $error("result beat with no command outstanding: product %0d status %0d occupancy %0d",
                 product, status, occupancy);
        end else begin
          want = pending_reports.pop_front();
          if (product !== want.product) begin
            err_cnt++;
            $error("product: expected %0d, got %0d", want.product, product);
          end
          if (status !== want.status) begin
            err_cnt++;
            $error("status: expected %0d, got %0d", want.status, status);
          end
          if (occupancy !== want.occupancy) begin
            err_cnt++;
            $error("occupancy: expected %0d, got %0d", want.occupancy, occupancy);
          end
        end
      end
      if (start && !busy) begin
        want = update_set(mode, operand);
        if (want.status == STAT_FULL) full_cnt++;
        if (want.status == STAT_ABSENT) absent_cnt++;
        pending_reports.insert(pending_reports.size(), want);
      end
    end
    errors       <= err_cnt;
    outstanding  <= pending_reports.size();
    full_drops   <= full_cnt;
    missing_pops <= absent_cnt;
  end

endmodule

// ===== test/tb_sorted_multiset_min_max_product_unit.sv =====
// ----------------------------------------------------------------------------
// Sorted multiset min-max product unit testbench
// Drives directed push and pop beats over the value extremes, equal values
// and an empty store, then bursts of fills past a full store, drains and mixed
// traffic under three idling phases. A separate checker predicts and compares each result.
// ----------------------------------------------------------------------------
module tb_sorted_multiset_min_max_product_unit;
  import smm_pkg::*;
  import smm_tb_pkg::*;

  localparam int          STALL_LIMIT = 2000;
  localparam logic [31:0] VAL_MIN     = 32'h8000_0000;
  localparam logic [31:0] VAL_MAX     = 32'h7fff_ffff;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic                     mode = MODE_PUSH;
  logic signed [DATA_W-1:0] operand = '0;
  logic                     busy;
  logic                     done;
  logic signed [PROD_W-1:0] product;
  logic [1:0]               status;
  logic [OCC_W-1:0]         occupancy;

  int          errors;
  int          outstanding;
  int          full_drops;
  int          missing_pops;
  int          idle_pct = 0;
  int          push_cnt = 0;
  int          pop_cnt = 0;
  int          stall_cycles = 0;
  logic [31:0] live_vals[$];

  always #4 clk = ~clk;

  sorted_multiset_min_max_product_unit dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .mode      (mode),
    .operand   (operand),
    .busy      (busy),
    .done      (done),
    .product   (product),
    .status    (status),
    .occupancy (occupancy)
  );

  smm_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .mode         (mode),
    .operand      (operand),
    .done         (done),
    .product      (product),
    .status       (status),
    .occupancy    (occupancy),
    .errors       (errors),
    .outstanding  (outstanding),
    .full_drops   (full_drops),
    .missing_pops (missing_pops)
  );

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("** sorted_multiset_min_max_product_unit: FAILED **");
        $finish;
      end
    end
  end

  function automatic logic [31:0] small_value();
    int t;
    t = $urandom_range(8);
    return 32'(t - 4);
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(7))
      0: return VAL_MIN;
      1: return VAL_MAX;
      2, 3: return small_value();
      4: return VAL_MIN + $urandom_range(3);
      5: return VAL_MAX - $urandom_range(3);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] held_value();
    if (live_vals.size() == 0) return pick_value();
    return live_vals[$urandom_range(live_vals.size() - 1)];
  endfunction

  task automatic send_beat(input logic m, input logic [31:0] v);
    int i;
    while ($urandom_range(99) < idle_pct) begin
      start   <= 1'b0;
      mode    <= 1'($urandom_range(1));
      operand <= $urandom();
      @(posedge clk);
    end
    start   <= 1'b1;
    mode    <= m;
    operand <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (m == MODE_PUSH) begin
      push_cnt++;
      if (live_vals.size() < CAPACITY) live_vals.insert(live_vals.size(), v);
    end else begin
      pop_cnt++;
      for (i = 0; i < live_vals.size(); i++) begin
        if (live_vals[i] == v) begin
          live_vals.delete(i);
          break;
        end
      end
    end
  endtask

  task automatic run_directed();
    send_beat(MODE_POP, 32'd5);
    send_beat(MODE_PUSH, 32'd0);
    send_beat(MODE_PUSH, VAL_MAX);
    send_beat(MODE_PUSH, VAL_MIN);
    send_beat(MODE_PUSH, VAL_MIN);
    send_beat(MODE_PUSH, VAL_MAX);
    send_beat(MODE_POP, 32'd0);
    send_beat(MODE_POP, 32'd7);
    send_beat(MODE_POP, VAL_MIN);
    send_beat(MODE_POP, VAL_MIN);
    send_beat(MODE_POP, VAL_MAX);
    send_beat(MODE_POP, VAL_MAX);
    send_beat(MODE_PUSH, VAL_MIN);
    send_beat(MODE_POP, VAL_MIN);
    send_beat(MODE_PUSH, 32'hffff_ffff);
    send_beat(MODE_PUSH, 32'hffff_ffff);
    send_beat(MODE_PUSH, 32'd1);
    send_beat(MODE_PUSH, 32'd3);
    send_beat(MODE_PUSH, 32'hffff_fffd);
    send_beat(MODE_PUSH, 32'd2);
    send_beat(MODE_POP, 32'd2);
    send_beat(MODE_POP, 32'hffff_fffd);
    send_beat(MODE_POP, 32'hffff_ffff);
    send_beat(MODE_POP, 32'd3);
    send_beat(MODE_POP, 32'hffff_ffff);
    send_beat(MODE_POP, 32'd1);
  endtask

  task automatic run_random(input int n_items);
    int sent;
    int len;
    int r;
    sent = 0;
    while (sent < n_items) begin
      len = $urandom_range(4, 40);
      case ($urandom_range(9))
        0, 1: begin
          while (live_vals.size() < CAPACITY) begin
            send_beat(MODE_PUSH, pick_value());
            sent++;
          end
          repeat ($urandom_range(1, 4)) begin
            send_beat(MODE_PUSH, pick_value());
            sent++;
          end
        end
        2, 3: begin
          while (live_vals.size() > 0) begin
            if ($urandom_range(9) == 0) send_beat(MODE_POP, pick_value());
            else send_beat(MODE_POP, held_value());
            sent++;
          end
        end
        4, 5, 6: begin
          repeat (len) begin
            r = $urandom_range(99);
            if (r < 55) send_beat(MODE_PUSH, pick_value());
            else if (r < 90) send_beat(MODE_POP, held_value());
            else send_beat(MODE_POP, pick_value());
            sent++;
          end
        end
        7, 8: begin
          repeat (len) begin
            send_beat(1'($urandom_range(1)), small_value());
            sent++;
          end
        end
        default: begin
          repeat (len) begin
            send_beat(1'($urandom_range(1)), $urandom());
            sent++;
          end
        end
      endcase
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    idle_pct = 27;
    run_directed();
    run_random(600);
    idle_pct = 86;
    run_random(620);
    idle_pct = 0;
    run_random(620);
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("Covered %0d beats (%0d pushes, %0d pops) over three idling phases.",
             push_cnt + pop_cnt, push_cnt, pop_cnt);
    $display("Pushes dropped on a full store: %0d; pops of absent values: %0d.",
             full_drops, missing_pops);
    if (errors == 0 && outstanding == 0) begin
      $display("** sorted_multiset_min_max_product_unit: PASSED **");
    end else begin
      $display("** sorted_multiset_min_max_product_unit: FAILED **");
    end
    $finish;
  end

endmodule

// ===== sorted_multiset_min_max_product_unit.f =====
sv/smm_pkg.sv
sv/smm_cell.sv
sv/smm_chain.sv
sv/sorted_multiset_min_max_product_unit.sv
test/smm_tb_pkg.sv
test/smm_checker.sv
test/tb_sorted_multiset_min_max_product_unit.sv
